// File: design/bfa_pkg.sv
// bfa_pkg: shared types and constants of the bitmap frame allocator
// used by bfa_front, bfa_queue, bfa_back and bitmap_frame_allocator
`default_nettype none

package bfa_pkg;

  localparam int CNT_W   = 16;
  localparam int ADDR_W  = 27;
  localparam int OP_W    = 2;
  localparam int PADDR_W = 32;
  localparam int STS_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MARK  = 2'd2
  } op_t;

  typedef enum logic [STS_W-1:0] {
    STS_DONE  = 2'd0,
    STS_OOM   = 2'd1,
    STS_RANGE = 2'd2,
    STS_SAME  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    K_ALLOC = 3'd0,
    K_FREE  = 3'd1,
    K_MARK  = 3'd2,
    K_RANGE = 3'd3,
    K_NOP   = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [CNT_W-1:0] frame;
  } req_t;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_EVAL  = 2'd2,
    S_OUT   = 2'd3
  } state_t;

endpackage

`default_nettype wire

// File: design/bfa_front.sv
// bfa_front: accepts request beats, turns the address into a frame number
// and classifies the request; depends on bfa_pkg
`default_nettype none

module bfa_front #(
  parameter int FRAME_BYTES = 4096
) (
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [bfa_pkg::OP_W-1:0]    in_op,
  input  wire logic [bfa_pkg::PADDR_W-1:0] in_phys_addr,
  input  wire logic [bfa_pkg::CNT_W-1:0]   frame_count,
  input  wire logic                        busy,
  input  wire logic                        q_full,
  output logic                             q_push,
  output bfa_pkg::req_t                    q_data
);

  localparam int FB_SH = $clog2(FRAME_BYTES);

  logic [bfa_pkg::PADDR_W-1:0] quot;
  logic                        in_range;

  assign quot     = in_phys_addr >> FB_SH;
  assign in_range = quot < {{(bfa_pkg::PADDR_W-bfa_pkg::CNT_W){1'b0}}, frame_count};
  assign in_stall = q_full || busy;
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    q_data.frame = quot[bfa_pkg::CNT_W-1:0];
    unique case (in_op)
      bfa_pkg::OP_ALLOC: q_data.kind = bfa_pkg::K_ALLOC;
      bfa_pkg::OP_FREE:  q_data.kind = in_range ? bfa_pkg::K_FREE : bfa_pkg::K_RANGE;
      bfa_pkg::OP_MARK:  q_data.kind = in_range ? bfa_pkg::K_MARK : bfa_pkg::K_RANGE;
      default:           q_data.kind = bfa_pkg::K_NOP;
    endcase
  end

endmodule

`default_nettype wire

// File: design/bfa_queue.sv
// bfa_queue: two-entry request queue between front and back
// depends on bfa_pkg
`default_nettype none

module bfa_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire bfa_pkg::req_t push_data,
  output logic               full,
  input  wire logic          pop,
  output bfa_pkg::req_t      pop_data,
  output logic               empty
);

  bfa_pkg::req_t slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: design/bfa_back.sv
// bfa_back: usage map memory, clearing pass, allocate scan, free/mark
// read-modify-write, free count and output register; depends on bfa_pkg
`default_nettype none

module bfa_back #(
  parameter int MAP_WORD_BITS = 32,
  parameter int MAP_WORDS     = 1024,
  parameter int FRAME_BYTES   = 4096,
  localparam int WORD_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_load,
  input  wire logic [WORD_W:0]            scan_end,
  output logic                            busy,
  input  wire logic                       q_empty,
  input  wire bfa_pkg::req_t              q_data,
  output logic                            q_pop,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [bfa_pkg::ADDR_W-1:0]      out_alloc_addr,
  output logic [bfa_pkg::STS_W-1:0]       out_status,
  output logic [bfa_pkg::CNT_W-1:0]       out_free_count
);

  localparam int BIT_SH = $clog2(MAP_WORD_BITS);
  localparam int FB_SH  = $clog2(FRAME_BYTES);
  localparam int WIDE_W = 48;

  logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [MAP_WORD_BITS-1:0] mem_rdata_r;
  logic [WORD_W-1:0]        mem_raddr;
  logic                     mem_we;
  logic [WORD_W-1:0]        mem_waddr;
  logic [MAP_WORD_BITS-1:0] mem_wdata;

  bfa_pkg::state_t          state_r, state_nxt;
  logic [WORD_W-1:0]        clr_r, clr_nxt;
  logic [WORD_W:0]          scan_r, scan_nxt;
  logic [WORD_W:0]          hint_r, hint_nxt;
  logic [bfa_pkg::CNT_W-1:0] free_cnt_r, free_cnt_nxt;
  bfa_pkg::req_t            cur_r, cur_nxt;
  logic [bfa_pkg::ADDR_W-1:0] res_addr_r, res_addr_nxt;
  bfa_pkg::status_t         res_sts_r, res_sts_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [bfa_pkg::ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  bfa_pkg::status_t            out_sts_r, out_sts_nxt;
  logic [bfa_pkg::CNT_W-1:0]   out_cnt_r, out_cnt_nxt;

  logic [WORD_W-1:0]        cur_word;
  logic [BIT_SH-1:0]        cur_bit;
  logic [BIT_SH-1:0]        zero_bit;
  logic [MAP_WORD_BITS-1:0] zero_mask;
  logic [MAP_WORD_BITS-1:0] cur_mask;
  logic [bfa_pkg::CNT_W-1:0] frame_sh;
  logic [WIDE_W-1:0]        frame_bytes;
  logic                     out_free;
  logic                     want_used;

  function automatic logic [BIT_SH-1:0] first_zero(input logic [MAP_WORD_BITS-1:0] w);
    logic [BIT_SH-1:0] idx;
    idx = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = BIT_SH'(i);
      end
    end
    return idx;
  endfunction

  assign frame_sh    = cur_r.frame >> BIT_SH;
  assign cur_word    = frame_sh[WORD_W-1:0];
  assign cur_bit     = cur_r.frame[BIT_SH-1:0];
  assign cur_mask    = {{(MAP_WORD_BITS-1){1'b0}}, 1'b1} << cur_bit;
  assign zero_bit    = first_zero(mem_rdata_r);
  assign zero_mask   = {{(MAP_WORD_BITS-1){1'b0}}, 1'b1} << zero_bit;
  assign frame_bytes = (WIDE_W'(scan_r[WORD_W-1:0]) << (BIT_SH + FB_SH))
                     | (WIDE_W'(zero_bit) << FB_SH);
  assign want_used   = (cur_r.kind == bfa_pkg::K_MARK);
  assign out_free    = !out_valid_r || !out_stall;
  assign busy        = (state_r == bfa_pkg::S_CLEAR);

  assign out_valid      = out_valid_r;
  assign out_alloc_addr = out_addr_r;
  assign out_status     = out_sts_r;
  assign out_free_count = out_cnt_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    scan_nxt      = scan_r;
    hint_nxt      = hint_r;
    free_cnt_nxt  = free_cnt_r;
    cur_nxt       = cur_r;
    res_addr_nxt  = res_addr_r;
    res_sts_nxt   = res_sts_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_addr_nxt  = out_addr_r;
    out_sts_nxt   = out_sts_r;
    out_cnt_nxt   = out_cnt_r;
    q_pop         = 1'b0;
    mem_raddr     = scan_r[WORD_W-1:0];
    mem_we        = 1'b0;
    mem_waddr     = cur_word;
    mem_wdata     = mem_rdata_r;

    unique case (state_r)
      bfa_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '1;
        hint_nxt  = scan_end;
        if (clr_r == WORD_W'(MAP_WORDS - 1)) begin
          state_nxt = bfa_pkg::S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      bfa_pkg::S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cur_nxt   = q_data;
          scan_nxt  = hint_r;
          state_nxt = bfa_pkg::S_EVAL;
          if (q_data.kind == bfa_pkg::K_ALLOC) begin
            mem_raddr = hint_r[WORD_W-1:0];
          end else begin
            mem_raddr = WORD_W'(q_data.frame >> BIT_SH);
          end
        end
      end
      bfa_pkg::S_EVAL: begin
        res_addr_nxt = '0;
        res_sts_nxt  = bfa_pkg::STS_DONE;
        state_nxt    = bfa_pkg::S_OUT;
        unique case (cur_r.kind)
          bfa_pkg::K_ALLOC: begin
            if (scan_r >= scan_end) begin
              res_sts_nxt = bfa_pkg::STS_OOM;
              hint_nxt    = scan_end;
            end else if (&mem_rdata_r) begin
              scan_nxt  = scan_r + 1'b1;
              mem_raddr = scan_nxt[WORD_W-1:0];
              state_nxt = bfa_pkg::S_EVAL;
            end else begin
              mem_we       = 1'b1;
              mem_waddr    = scan_r[WORD_W-1:0];
              mem_wdata    = mem_rdata_r | zero_mask;
              free_cnt_nxt = free_cnt_r - 1'b1;
              hint_nxt     = scan_r;
              res_addr_nxt = frame_bytes[bfa_pkg::ADDR_W-1:0];
            end
          end
          bfa_pkg::K_FREE, bfa_pkg::K_MARK: begin
            if (mem_rdata_r[cur_bit] == want_used) begin
              res_sts_nxt = bfa_pkg::STS_SAME;
            end else begin
              mem_we = 1'b1;
              if (want_used) begin
                mem_wdata    = mem_rdata_r | cur_mask;
                free_cnt_nxt = free_cnt_r - 1'b1;
              end else begin
                mem_wdata    = mem_rdata_r & ~cur_mask;
                free_cnt_nxt = free_cnt_r + 1'b1;
                if ({1'b0, cur_word} < hint_r) begin
                  hint_nxt = {1'b0, cur_word};
                end
              end
            end
          end
          bfa_pkg::K_RANGE: res_sts_nxt = bfa_pkg::STS_RANGE;
          default:          res_sts_nxt = bfa_pkg::STS_DONE;
        endcase
      end
      bfa_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_sts_nxt   = res_sts_r;
          out_cnt_nxt   = free_cnt_r;
          state_nxt     = bfa_pkg::S_IDLE;
        end
      end
      default: state_nxt = bfa_pkg::S_IDLE;
    endcase

    if (cfg_load) begin
      state_nxt    = bfa_pkg::S_CLEAR;
      clr_nxt      = '0;
      free_cnt_nxt = '0;
      hint_nxt     = scan_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfa_pkg::S_CLEAR;
      clr_r       <= '0;
      free_cnt_r  <= '0;
      hint_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_cnt_r  <= free_cnt_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    cur_r      <= cur_nxt;
    res_addr_r <= res_addr_nxt;
    res_sts_r  <= res_sts_nxt;
    out_addr_r <= out_addr_nxt;
    out_sts_r  <= out_sts_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= map_mem[mem_raddr];
  end

endmodule

`default_nettype wire

// File: design/bitmap_frame_allocator.sv
// bitmap_frame_allocator: first-fit page frame allocator top level
// holds the frame count register; uses bfa_pkg, bfa_front, bfa_queue, bfa_back
//
//   channel  ports                                         direction
//   in       in_valid/in_stall, in_op, in_phys_addr        request beats in
//   out      out_valid/out_stall, out_alloc_addr,          result beats out
//            out_status, out_free_count
//   cfg      cfg_we, cfg_wdata                             frame count write
//
// free, mark, out of range, unused op: queued, popped in S_IDLE, evaluated
// in S_EVAL, output register loaded in S_OUT; allocate adds a map memory read per
// full word passed from the lowest possibly free word (hint register)
// after reset and after every cfg write a clearing pass writes all MAP_WORDS
// words (1024 by default) with in_stall high
// a two-entry queue keeps taking beats while a result sits stalled at the output
// FRAME_BYTES and MAP_WORD_BITS are powers of two
`default_nettype none

module bitmap_frame_allocator #(
  parameter int MAX_FRAMES    = 32768,
  parameter int FRAME_BYTES   = 4096,
  parameter int MAP_WORD_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [bfa_pkg::CNT_W-1:0]   cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [bfa_pkg::OP_W-1:0]    in_op,
  input  wire logic [bfa_pkg::PADDR_W-1:0] in_phys_addr,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [bfa_pkg::ADDR_W-1:0]       out_alloc_addr,
  output logic [bfa_pkg::STS_W-1:0]        out_status,
  output logic [bfa_pkg::CNT_W-1:0]        out_free_count
);

  localparam int EFF_FRAMES = (MAX_FRAMES < 65536) ? MAX_FRAMES : 65535;
  localparam int RST_FRAMES = (EFF_FRAMES < 32768) ? EFF_FRAMES : 32768;
  localparam int MAP_WORDS  = (EFF_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WORD_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_SH     = $clog2(MAP_WORD_BITS);

  logic [bfa_pkg::CNT_W-1:0] frame_count_r, frame_count_nxt;
  logic                      cfg_load_r;
  logic [bfa_pkg::CNT_W:0]   fc_round;
  logic [bfa_pkg::CNT_W:0]   fc_words;
  logic [WORD_W:0]           scan_end;
  logic                      back_busy;
  logic                      q_full;
  logic                      q_empty;
  logic                      q_push;
  logic                      q_pop;
  bfa_pkg::req_t             q_wdata;
  bfa_pkg::req_t             q_rdata;

  assign frame_count_nxt = (cfg_wdata > bfa_pkg::CNT_W'(EFF_FRAMES))
                         ? bfa_pkg::CNT_W'(EFF_FRAMES) : cfg_wdata;
  assign fc_round = {1'b0, frame_count_r} + (bfa_pkg::CNT_W+1)'(MAP_WORD_BITS - 1);
  assign fc_words = fc_round >> BIT_SH;
  assign scan_end = fc_words[WORD_W:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= bfa_pkg::CNT_W'(RST_FRAMES);
      cfg_load_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        frame_count_r <= frame_count_nxt;
      end
      cfg_load_r <= cfg_we;
    end
  end

  bfa_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_phys_addr (in_phys_addr),
    .frame_count  (frame_count_r),
    .busy         (back_busy || cfg_load_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  bfa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  bfa_back #(
    .MAP_WORD_BITS (MAP_WORD_BITS),
    .MAP_WORDS     (MAP_WORDS),
    .FRAME_BYTES   (FRAME_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_load       (cfg_load_r),
    .scan_end       (scan_end),
    .busy           (back_busy),
    .q_empty        (q_empty),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_alloc_addr (out_alloc_addr),
    .out_status     (out_status),
    .out_free_count (out_free_count)
  );

endmodule

`default_nettype wire
